@@ hw/rtl/hgbs_pkg.sv @@
// ----------------------------------------------------------------------------
// hgbs_pkg
// Shared types, constants and width helpers for the height grid sampler.
// ----------------------------------------------------------------------------
package hgbs_pkg;

	localparam int DEF_GRID_COLS = 128;
	localparam int DEF_GRID_ROWS = 128;

	localparam int IDX_W       = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [23:0] INV_CELL_RESET = 24'h010000;
	localparam logic [7:0]  GRID_DIM_RESET = 8'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_PRESENT,
		REG_BASE_X,
		REG_BASE_Y,
		REG_INV_CELL_X,
		REG_INV_CELL_Y,
		REG_GRID_COLS,
		REG_GRID_ROWS
	} hgbs_reg_t;

	typedef enum logic [1:0] {
		ITEM_DROP,
		ITEM_WRITE,
		ITEM_QUERY,
		ITEM_MISS
	} hgbs_kind_t;

	typedef struct packed {
		logic               map_present;
		logic signed [31:0] base_x;
		logic signed [31:0] base_y;
		logic [23:0]        inv_cell_x;
		logic [23:0]        inv_cell_y;
		logic [7:0]         grid_cols;
		logic [7:0]         grid_rows;
	} hgbs_cfg_t;

	typedef struct packed {
		logic                  empty;
		logic [FIFO_CNT_W-1:0] count;
	} hgbs_fifo_stat_t;

	function automatic int idx_width(input int n);
		return ($clog2(n) < 2) ? 2 : $clog2(n);
	endfunction

	function automatic int item_width(input int cols, input int rows);
		return 2 + 2 + 2 * (idx_width(rows) - 1) + 2 * (idx_width(cols) - 1) + 48;
	endfunction

endpackage

@@ hw/rtl/height_grid_bilinear_sampler.sv @@
// ----------------------------------------------------------------------------
// height_grid_bilinear_sampler
// Bilinear height-map sampler over a signed 16-bit elevation grid.
// ----------------------------------------------------------------------------
// The block takes one item per clock while item_stall is low: a grid write
// (mode 0, no result) or a query (mode 1, one result). A query runs through a
// three-stage mapping pipeline, an eight-beat queue and a five-stage blend
// pipeline; its result is held back further only while the result side
// stalls. The grid sits in four RAM banks split by row and column parity, so
// the four neighbor cells of a query come out in one read of each bank. Items
// are served in order, so a query always sees every earlier write. Grid
// contents are undefined after reset and there is no clearing pass; read only
// cells that have been written. Write configuration only while no item is in
// flight.
// ----------------------------------------------------------------------------
module height_grid_bilinear_sampler import hgbs_pkg::*; #(
	parameter int GRID_COLS = DEF_GRID_COLS,
	parameter int GRID_ROWS = DEF_GRID_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 mode,
	input  logic [6:0]           cell_col,
	input  logic [6:0]           cell_row,
	input  logic signed [15:0]   cell_height,
	input  logic signed [31:0]   query_x,
	input  logic signed [31:0]   query_y,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [23:0]   height,
	output logic                 in_range
);

	localparam int ITEM_W = item_width(GRID_COLS, GRID_ROWS);

	hgbs_cfg_t       cfg_q;
	hgbs_fifo_stat_t fifo_stat;
	logic            push, pop;
	logic [ITEM_W-1:0] push_item, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_present <= 1'b0;
			cfg_q.base_x      <= '0;
			cfg_q.base_y      <= '0;
			cfg_q.inv_cell_x  <= INV_CELL_RESET;
			cfg_q.inv_cell_y  <= INV_CELL_RESET;
			cfg_q.grid_cols   <= GRID_DIM_RESET;
			cfg_q.grid_rows   <= GRID_DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAP_PRESENT: cfg_q.map_present <= cfg_data[0];
				REG_BASE_X:      cfg_q.base_x      <= $signed(cfg_data);
				REG_BASE_Y:      cfg_q.base_y      <= $signed(cfg_data);
				REG_INV_CELL_X:  cfg_q.inv_cell_x  <= cfg_data[23:0];
				REG_INV_CELL_Y:  cfg_q.inv_cell_y  <= cfg_data[23:0];
				REG_GRID_COLS:   cfg_q.grid_cols   <= cfg_data[7:0];
				REG_GRID_ROWS:   cfg_q.grid_rows   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	hgbs_front #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS),
		.ITEM_W    (ITEM_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.mode        (mode),
		.cell_col    (cell_col),
		.cell_row    (cell_row),
		.cell_height (cell_height),
		.query_x     (query_x),
		.query_y     (query_y),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.push_item   (push_item)
	);

	hgbs_fifo #(
		.WIDTH (ITEM_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_item),
		.pop       (pop),
		.pop_data  (head),
		.stat      (fifo_stat)
	);

	hgbs_back #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS),
		.ITEM_W    (ITEM_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_stat    (fifo_stat),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.height       (height),
		.in_range     (in_range)
	);

endmodule

@@ hw/rtl/hgbs_ram.sv @@
// ----------------------------------------------------------------------------
// hgbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hgbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/hgbs_front.sv @@
// ----------------------------------------------------------------------------
// hgbs_front
// Accepts items, maps query positions to grid cells and fractions, and
// classifies each item before handing it to the queue.
// ----------------------------------------------------------------------------
module hgbs_front import hgbs_pkg::*; #(
	parameter int GRID_COLS = DEF_GRID_COLS,
	parameter int GRID_ROWS = DEF_GRID_ROWS,
	parameter int ITEM_W    = item_width(DEF_GRID_COLS, DEF_GRID_ROWS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hgbs_cfg_t          cfg,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               mode,
	input  logic [6:0]         cell_col,
	input  logic [6:0]         cell_row,
	input  logic signed [15:0] cell_height,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  hgbs_fifo_stat_t    fifo_stat,
	output logic               push,
	output logic [ITEM_W-1:0]  push_item
);

	localparam int CW    = idx_width(GRID_COLS);
	localparam int RW    = idx_width(GRID_ROWS);
	localparam int D_W   = 33;
	localparam int M_W   = 46;
	localparam int P_W   = 57;
	localparam int SUM_W = FIFO_CNT_W + 1;

	logic accept;

	logic                   valid_s1, valid_s2, valid_s3;
	logic                   mode_s1, mode_s2, mode_s3;
	logic                   wok_s1, wok_s2, wok_s3;
	logic [CW-1:0]          col_s1, col_s2, col_s3;
	logic [RW-1:0]          row_s1, row_s2, row_s3;
	logic [15:0]            hgt_s1, hgt_s2, hgt_s3;
	logic signed [D_W-1:0]  diff_s1 [2];
	logic signed [M_W-1:0]  lo_s2 [2];
	logic signed [M_W-1:0]  hi_s2 [2];
	logic signed [P_W-1:0]  p_s3 [2];

	logic [IDX_W-1:0]       col_idx, row_idx;
	logic [11:0]            inv_lo [2];
	logic [11:0]            inv_hi [2];
	logic [IDX_W-1:0]       dim [2];
	logic signed [IDX_W:0]  lim [2];
	logic signed [D_W-1:0]  cpos [2];
	logic                   ok [2];
	logic [15:0]            frac [2];
	logic [CW-1:0]          cx, cx1;
	logic [RW-1:0]          ry, ry1;
	logic [1:0]             inflight;
	logic [SUM_W-1:0]       occupancy;

	hgbs_kind_t    kind;
	logic          par_r, par_c;
	logic [RW-2:0] ra_e, ra_o;
	logic [CW-2:0] ca_e, ca_o;
	logic [15:0]   t_f, u_f;

	assign accept  = item_valid && !item_stall;
	assign col_idx = IDX_W'(cell_col);
	assign row_idx = IDX_W'(cell_row);
	assign inv_lo[0] = cfg.inv_cell_x[11:0];
	assign inv_hi[0] = cfg.inv_cell_x[23:12];
	assign inv_lo[1] = cfg.inv_cell_y[11:0];
	assign inv_hi[1] = cfg.inv_cell_y[23:12];

	assign inflight  = 2'(valid_s1) + 2'(valid_s2) + 2'(valid_s3);
	assign occupancy = SUM_W'(fifo_stat.count) + SUM_W'(inflight);
	assign item_stall = occupancy >= SUM_W'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1    <= mode;
		wok_s1     <= (col_idx < IDX_W'(GRID_COLS)) && (row_idx < IDX_W'(GRID_ROWS));
		col_s1     <= col_idx[CW-1:0];
		row_s1     <= row_idx[RW-1:0];
		hgt_s1     <= cell_height;
		diff_s1[0] <= {query_x[31], query_x} - {cfg.base_x[31], cfg.base_x};
		diff_s1[1] <= {query_y[31], query_y} - {cfg.base_y[31], cfg.base_y};

		mode_s2 <= mode_s1;
		wok_s2  <= wok_s1;
		col_s2  <= col_s1;
		row_s2  <= row_s1;
		hgt_s2  <= hgt_s1;
		for (int i = 0; i < 2; i++) begin
			lo_s2[i] <= diff_s1[i] * $signed({1'b0, inv_lo[i]});
			hi_s2[i] <= diff_s1[i] * $signed({1'b0, inv_hi[i]});
		end

		mode_s3 <= mode_s2;
		wok_s3  <= wok_s2;
		col_s3  <= col_s2;
		row_s3  <= row_s2;
		hgt_s3  <= hgt_s2;
		for (int i = 0; i < 2; i++) begin
			p_s3[i] <= (P_W'(hi_s2[i]) <<< 12) + P_W'(lo_s2[i]);
		end
	end

	always_comb begin
		dim[0] = (IDX_W'(cfg.grid_cols) < IDX_W'(GRID_COLS)) ?
			IDX_W'(cfg.grid_cols) : IDX_W'(GRID_COLS);
		dim[1] = (IDX_W'(cfg.grid_rows) < IDX_W'(GRID_ROWS)) ?
			IDX_W'(cfg.grid_rows) : IDX_W'(GRID_ROWS);
		for (int i = 0; i < 2; i++) begin
			lim[i]  = $signed({1'b0, dim[i]}) - $signed((IDX_W + 1)'(2));
			cpos[i] = $signed(p_s3[i][P_W-1:24]);
			frac[i] = p_s3[i][23:8];
			ok[i]   = !cpos[i][D_W-1] && (cpos[i] < D_W'(lim[i]));
		end
	end

	always_comb begin
		cx  = cpos[0][CW-1:0];
		cx1 = cx + CW'(1);
		ry  = cpos[1][RW-1:0];
		ry1 = ry + RW'(1);
		if (!mode_s3) begin
			kind  = wok_s3 ? ITEM_WRITE : ITEM_DROP;
			par_c = col_s3[0];
			par_r = row_s3[0];
			ca_e  = col_s3[CW-1:1];
			ca_o  = col_s3[CW-1:1];
			ra_e  = row_s3[RW-1:1];
			ra_o  = row_s3[RW-1:1];
		end else begin
			kind  = (cfg.map_present && ok[0] && ok[1]) ? ITEM_QUERY : ITEM_MISS;
			par_c = cx[0];
			par_r = ry[0];
			ca_e  = cx1[CW-1:1];
			ca_o  = cx[CW-1:1];
			ra_e  = ry1[RW-1:1];
			ra_o  = ry[RW-1:1];
		end
		t_f = frac[0];
		u_f = frac[1];
	end

	assign push      = valid_s3 && (kind != ITEM_DROP);
	assign push_item = {kind, par_r, par_c, ra_e, ra_o, ca_e, ca_o, t_f, u_f, hgt_s3};

endmodule

@@ hw/rtl/hgbs_fifo.sv @@
// ----------------------------------------------------------------------------
// hgbs_fifo
// Short queue between the classifier and the blend pipeline.
// ----------------------------------------------------------------------------
module hgbs_fifo import hgbs_pkg::*; #(
	parameter int WIDTH = item_width(DEF_GRID_COLS, DEF_GRID_ROWS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output hgbs_fifo_stat_t  stat
);

	logic [WIDTH-1:0]      mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

@@ hw/rtl/hgbs_back.sv @@
// ----------------------------------------------------------------------------
// hgbs_back
// Performs grid writes and reads the four neighbor cells from parity banks,
// then blends them and registers the result.
// ----------------------------------------------------------------------------
module hgbs_back import hgbs_pkg::*; #(
	parameter int GRID_COLS = DEF_GRID_COLS,
	parameter int GRID_ROWS = DEF_GRID_ROWS,
	parameter int ITEM_W    = item_width(DEF_GRID_COLS, DEF_GRID_ROWS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hgbs_fifo_stat_t    fifo_stat,
	input  logic [ITEM_W-1:0]  head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [23:0] height,
	output logic               in_range
);

	localparam int CW         = idx_width(GRID_COLS);
	localparam int RW         = idx_width(GRID_ROWS);
	localparam int BANK_AW    = (CW - 1) + (RW - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int PR_W       = 34;
	localparam int M_W        = 52;

	logic [1:0]    kind_bits;
	hgbs_kind_t    kind_h;
	logic          par_r_h, par_c_h;
	logic [RW-2:0] ra_e_h, ra_o_h;
	logic [CW-2:0] ca_e_h, ca_o_h;
	logic [15:0]   t_h, u_h, wd_h;

	logic               en;
	logic [BANK_AW-1:0] baddr [4];
	logic               bwe [4];
	logic [15:0]        bank_rd [4];

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        hit_s1, hit_s2, hit_s3, hit_s4;
	logic        par_r_s1, par_c_s1;
	logic [15:0] t_s1, u_s1, u_s2, u_s3;

	logic signed [15:0]     h00, h01, h10, h11;
	logic [16:0]            wt1, wu1;
	logic signed [PR_W-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic signed [PR_W-1:0] rowa_s3, rowb_s3;
	logic signed [M_W-1:0]  m0_s4, m1_s4;
	logic signed [M_W-1:0]  blend;

	logic               result_valid_q;
	logic signed [23:0] height_q;
	logic               in_range_q;

	assign {kind_bits, par_r_h, par_c_h, ra_e_h, ra_o_h, ca_e_h, ca_o_h, t_h, u_h, wd_h} = head;
	assign kind_h = hgbs_kind_t'(kind_bits);

	assign en  = !(result_valid_q && result_stall);
	assign pop = en && !fifo_stat.empty;

	for (genvar g = 0; g < 4; g++) begin : g_bank
		localparam bit ROW_ODD = (g >= 2);
		localparam bit COL_ODD = (g % 2 == 1);

		assign baddr[g] = {ROW_ODD ? ra_o_h : ra_e_h, COL_ODD ? ca_o_h : ca_e_h};
		assign bwe[g]   = pop && (kind_h == ITEM_WRITE) &&
			(par_r_h == ROW_ODD) && (par_c_h == COL_ODD);

		hgbs_ram #(
			.WIDTH(16),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (bwe[g]),
			.waddr (baddr[g]),
			.wdata (wd_h),
			.re    (en),
			.raddr (baddr[g]),
			.rdata (bank_rd[g])
		);
	end

	always_comb begin
		h00 = $signed(bank_rd[{par_r_s1, par_c_s1}]);
		h01 = $signed(bank_rd[{par_r_s1, ~par_c_s1}]);
		h10 = $signed(bank_rd[{~par_r_s1, par_c_s1}]);
		h11 = $signed(bank_rd[{~par_r_s1, ~par_c_s1}]);
		wt1 = 17'h10000 - {1'b0, t_s1};
		wu1 = 17'h10000 - {1'b0, u_s3};
		blend = m0_s4 + m1_s4 + $signed(M_W'(1) <<< 23);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			valid_s3       <= 1'b0;
			valid_s4       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1       <= pop && (kind_h != ITEM_WRITE);
			valid_s2       <= valid_s1;
			valid_s3       <= valid_s2;
			valid_s4       <= valid_s3;
			result_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1   <= (kind_h == ITEM_QUERY);
			par_r_s1 <= par_r_h;
			par_c_s1 <= par_c_h;
			t_s1     <= t_h;
			u_s1     <= u_h;

			hit_s2 <= hit_s1;
			u_s2   <= u_s1;
			p00_s2 <= $signed({1'b0, wt1}) * h00;
			p01_s2 <= $signed({2'b0, t_s1}) * h01;
			p10_s2 <= $signed({1'b0, wt1}) * h10;
			p11_s2 <= $signed({2'b0, t_s1}) * h11;

			hit_s3  <= hit_s2;
			u_s3    <= u_s2;
			rowa_s3 <= p00_s2 + p01_s2;
			rowb_s3 <= p10_s2 + p11_s2;

			hit_s4 <= hit_s3;
			m0_s4  <= $signed({1'b0, wu1}) * rowa_s3;
			m1_s4  <= $signed({2'b0, u_s3}) * rowb_s3;

			height_q   <= hit_s4 ? blend[47:24] : '0;
			in_range_q <= hit_s4;
		end
	end

	assign result_valid = result_valid_q;
	assign height       = height_q;
	assign in_range     = in_range_q;

endmodule
